// ----- hw/rtl/digclk_pkg.sv -----
// digclk_pkg: shared types, codes and decode functions for the digital clock
// display block. No dependencies.

package digclk_pkg;

    // widths of the clock fields and registers
    localparam int unsigned TickW = 10;
    localparam int unsigned HourW = 5;
    localparam int unsigned MinW  = 6;
    localparam int unsigned SecW  = 6;
    localparam int unsigned ScanW = 3;
    localparam int unsigned SegW  = 8;

    // wrap limits of the time fields
    localparam logic [HourW-1:0] HOUR_LAST = 5'd23;
    localparam logic [MinW-1:0]  MIN_LAST  = 6'd59;
    localparam logic [SecW-1:0]  SEC_LAST  = 6'd59;

    // configuration reset values and register indexes
    localparam logic [TickW-1:0] TPS_RESET   = 10'd1000;
    localparam logic [TickW-1:0] BLINK_RESET = 10'd400;
    localparam logic             CFG_TPS     = 1'b0;
    localparam logic             CFG_BLINK   = 1'b1;

    // input kinds carried on tuser
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_KEY  = 1'b1;

    // key ids
    localparam logic [1:0] KEY_SELECT  = 2'd0;
    localparam logic [1:0] KEY_CONFIRM = 2'd1;
    localparam logic [1:0] KEY_PLUS    = 2'd2;
    localparam logic [1:0] KEY_MINUS   = 2'd3;

    // press kinds
    localparam logic [1:0] PRESS_SHORT  = 2'd0;
    localparam logic [1:0] PRESS_LONG   = 2'd1;
    localparam logic [1:0] PRESS_REPEAT = 2'd2;
    // press kind outside the defined set, ignored by the block
    localparam logic [1:0] PRESS_UNUSED = 2'd3;

    // dash between digit pairs
    localparam logic [SegW-1:0] SEG_DASH = 8'h40;

    typedef enum logic [1:0] {
        MODE_RUN  = 2'd0,
        MODE_HOUR = 2'd1,
        MODE_MIN  = 2'd2,
        MODE_SEC  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } bcd_t;

    // split a value below 64 into tens and ones by range compares
    function automatic bcd_t bcd_split(input logic [5:0] v);
        bcd_t       r;
        logic [5:0] base;
        logic [5:0] rem;
        if (v >= 6'd60) begin
            r.tens = 4'd6;
            base   = 6'd60;
        end else if (v >= 6'd50) begin
            r.tens = 4'd5;
            base   = 6'd50;
        end else if (v >= 6'd40) begin
            r.tens = 4'd4;
            base   = 6'd40;
        end else if (v >= 6'd30) begin
            r.tens = 4'd3;
            base   = 6'd30;
        end else if (v >= 6'd20) begin
            r.tens = 4'd2;
            base   = 6'd20;
        end else if (v >= 6'd10) begin
            r.tens = 4'd1;
            base   = 6'd10;
        end else begin
            r.tens = 4'd0;
            base   = 6'd0;
        end
        rem    = v - base;
        r.ones = rem[3:0];
        return r;
    endfunction

    // seven-segment pattern of one decimal digit
    function automatic logic [SegW-1:0] seg_of(input logic [3:0] d);
        logic [SegW-1:0] p;
        unique case (d)
            4'd0:    p = 8'h3f;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5b;
            4'd3:    p = 8'h4f;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6d;
            4'd6:    p = 8'h7d;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7f;
            4'd9:    p = 8'h67;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

// ----- hw/rtl/digital_clock_display_and_set.sv -----
// digital_clock_display_and_set: 24-hour clock with eight-digit multiplexed
// seven-segment scan and key-driven time setting. Uses digclk_pkg.
// The result is registered: it is on m_ in the cycle after its input is accepted.
// Throughput: one transaction per cycle while m_tready takes the results; the clock
// state and the result register both update at the accepting edge, so items follow back to back.
// Reset (aresetn low, synchronous): time, tick count, scan index and mode go
// to zero (run mode), ticks_per_second to 1000, blink_threshold to 400.

module digital_clock_display_and_set
    import digclk_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [9:0]  cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key [1:0], press_kind [3:2], zero [7:4]
    input  logic        s_tuser,   // action [0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // digit_select [2:0], segments [10:3], mode [12:11], hours [17:13],
    // minutes [23:18], seconds [29:24], zero [31:30]
    output logic [31:0] m_tdata,
    output logic        m_tuser    // drive_valid [0]
);

    // configuration registers
    logic [TickW-1:0] tps_reg;
    logic [TickW-1:0] blink_reg;

    // clock state
    logic [TickW-1:0] tick_reg,  tick_next;
    logic [ScanW-1:0] scan_reg,  scan_next;
    logic [SecW-1:0]  sec_reg,   sec_next;
    logic [MinW-1:0]  min_reg,   min_next;
    logic [HourW-1:0] hour_reg,  hour_next;
    mode_t            mode_reg,  mode_next;

    // result register
    logic             m_valid_reg;
    logic [SegW-1:0]  seg_reg,   seg_next;
    logic [ScanW-1:0] sel_reg;
    logic             drive_reg;

    logic             in_fire;
    logic [1:0]       in_key;
    logic [1:0]       in_kind;
    logic [TickW:0]   t_inc;
    bcd_t             hour_bcd;
    bcd_t             min_bcd;
    bcd_t             sec_bcd;
    logic [SegW-1:0]  digit_seg;
    logic             edited;
    logic             is_press;
    logic             is_step;

    assign in_key   = s_tdata[1:0];
    assign in_kind  = s_tdata[3:2];
    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg   <= TPS_RESET;
            blink_reg <= BLINK_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_TPS:   tps_reg   <= cfg_wdata;
                CFG_BLINK: blink_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // digit decode of the current time
    assign hour_bcd = bcd_split({1'b0, hour_reg});
    assign min_bcd  = bcd_split(min_reg);
    assign sec_bcd  = bcd_split(sec_reg);

    always_comb begin
        unique case (scan_reg)
            3'd0:    digit_seg = seg_of(hour_bcd.tens);
            3'd1:    digit_seg = seg_of(hour_bcd.ones);
            3'd3:    digit_seg = seg_of(min_bcd.tens);
            3'd4:    digit_seg = seg_of(min_bcd.ones);
            3'd6:    digit_seg = seg_of(sec_bcd.tens);
            3'd7:    digit_seg = seg_of(sec_bcd.ones);
            default: digit_seg = SEG_DASH;
        endcase
    end

    // is the scanned digit part of the pair being edited
    always_comb begin
        unique case (mode_reg)
            MODE_HOUR: edited = (scan_reg == 3'd0) || (scan_reg == 3'd1);
            MODE_MIN:  edited = (scan_reg == 3'd3) || (scan_reg == 3'd4);
            MODE_SEC:  edited = (scan_reg == 3'd6) || (scan_reg == 3'd7);
            default:   edited = 1'b0;
        endcase
    end

    assign t_inc    = {1'b0, tick_reg} + 1'b1;
    assign is_press = (in_kind == PRESS_SHORT) || (in_kind == PRESS_LONG);
    assign is_step  = (in_kind == PRESS_SHORT) || (in_kind == PRESS_REPEAT);

    // next state and result for one transaction
    always_comb begin
        tick_next = tick_reg;
        scan_next = scan_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        mode_next = mode_reg;
        seg_next  = '0;

        if (s_tuser == ACT_TICK) begin
            // scan one digit, blank it during the blink window
            if (!(edited && (t_inc <= {1'b0, blink_reg}))) begin
                seg_next = digit_seg;
            end
            // millisecond count and time roll-over
            if (t_inc >= {1'b0, tps_reg}) begin
                tick_next = '0;
                if (sec_reg >= SEC_LAST) begin
                    sec_next = '0;
                    if (min_reg >= MIN_LAST) begin
                        min_next  = '0;
                        hour_next = (hour_reg >= HOUR_LAST) ? '0 : hour_reg + 1'b1;
                    end else begin
                        min_next = min_reg + 1'b1;
                    end
                end else begin
                    sec_next = sec_reg + 1'b1;
                end
            end else begin
                tick_next = t_inc[TickW-1:0];
            end
            scan_next = scan_reg + 1'b1;
        end else if (in_kind != PRESS_UNUSED) begin
            // key handling
            case (in_key)
                KEY_CONFIRM: begin
                    mode_next = MODE_RUN;
                end
                KEY_SELECT: begin
                    if (is_press) begin
                        unique case (mode_reg)
                            MODE_RUN:  mode_next = MODE_HOUR;
                            MODE_HOUR: mode_next = MODE_MIN;
                            MODE_MIN:  mode_next = MODE_SEC;
                            MODE_SEC:  mode_next = MODE_HOUR;
                            default:   mode_next = MODE_RUN;
                        endcase
                    end
                end
                default: begin
                    // plus or minus on the edited field, wrap without carry
                    if (is_step) begin
                        case (mode_reg)
                            MODE_HOUR: begin
                                if (in_key == KEY_PLUS) begin
                                    hour_next = (hour_reg >= HOUR_LAST) ? '0
                                                                        : hour_reg + 1'b1;
                                end else begin
                                    hour_next = (hour_reg == '0) ? HOUR_LAST
                                                                 : hour_reg - 1'b1;
                                end
                            end
                            MODE_MIN: begin
                                if (in_key == KEY_PLUS) begin
                                    min_next = (min_reg >= MIN_LAST) ? '0 : min_reg + 1'b1;
                                end else begin
                                    min_next = (min_reg == '0) ? MIN_LAST : min_reg - 1'b1;
                                end
                            end
                            MODE_SEC: begin
                                if (in_key == KEY_PLUS) begin
                                    sec_next = (sec_reg >= SEC_LAST) ? '0 : sec_reg + 1'b1;
                                end else begin
                                    sec_next = (sec_reg == '0) ? SEC_LAST : sec_reg - 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

    // clock state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            scan_reg <= '0;
            sec_reg  <= '0;
            min_reg  <= '0;
            hour_reg <= '0;
            mode_reg <= MODE_RUN;
        end else if (in_fire) begin
            tick_reg <= tick_next;
            scan_reg <= scan_next;
            sec_reg  <= sec_next;
            min_reg  <= min_next;
            hour_reg <= hour_next;
            mode_reg <= mode_next;
        end
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sel_reg   <= scan_reg;
            seg_reg   <= seg_next;
            drive_reg <= (s_tuser == ACT_TICK);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = drive_reg;
    assign m_tdata  = {2'b00, sec_reg, min_reg, hour_reg, mode_reg, seg_reg, sel_reg};

    // time fields stay in range
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (hour_reg <= HOUR_LAST) && (min_reg <= MIN_LAST) && (sec_reg <= SEC_LAST))
        else $error("time field out of range");

    // an accepted tick moves the scan to the next digit
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser == ACT_TICK) |=> (scan_reg == $past(scan_reg) + 3'd1))
        else $error("scan index did not advance on tick");

    // a key event leaves the tick count and scan untouched
    a_key_no_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_tuser == ACT_KEY) |=> ($stable(tick_reg) && $stable(scan_reg)))
        else $error("key event changed tick count or scan");

    // key results never drive segments
    a_key_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !drive_reg) |-> (seg_reg == '0))
        else $error("key result carries segments");

endmodule
